/* hdl/krst_pkg.sv */
// Package for the keyed running statistics table.
// Holds field widths, parameter defaults, the result status codes, the controller
// states and the command and status structs shared by the controller and datapath.
package krst_pkg;

  // Parameter defaults.
  localparam int unsigned TABLE_DEPTH_DEF    = 64;
  localparam int unsigned MEAN_FRAC_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned MEAN_OUT_W = 48;
  localparam int unsigned CFG_W      = 7;

  // Reset value of the keys-in-use register.
  localparam logic [CFG_W-1:0] KEYS_IN_USE_RESET = 7'd64;

  // Status code returned with every result word.
  typedef enum logic [1:0] {
    STATUS_NEW     = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_CLEARED = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_DSTART,
    ST_DIV,
    ST_SUM,
    ST_WB,
    ST_MISS,
    ST_CLR
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic idx_inc;
    logic hit_load;
    logic div_start;
    logic mean_sum;
    logic write_back;
    logic append;
    logic drop;
    logic clear;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_end;
    logic key_hit;
    logic table_full;
    logic div_done;
  } dp_stat_t;

endpackage

/* hdl/krst_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the key store and the statistics store. Depends on krst_pkg.
module krst_ram #(
  parameter int unsigned WIDTH = krst_pkg::KEY_W,
  parameter int unsigned DEPTH = krst_pkg::TABLE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/krst_div.sv */
// Iterative restoring divider, one quotient bit per cycle, for the mean update.
// Returns the floor quotient of a signed dividend by a positive divisor and a
// flag for a nonzero remainder. Depends on krst_pkg.
module krst_div #(
  parameter int unsigned DW = krst_pkg::SAMPLE_W + krst_pkg::MEAN_FRAC_BITS_DEF + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [DW-1:0]          dividend_i,
  input  logic [krst_pkg::COUNT_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic signed [DW-1:0]          quot_o,
  output logic                          rem_nz_o
);

  localparam int unsigned NW = krst_pkg::COUNT_W;
  localparam int unsigned CNTW = $clog2(DW + 1);

  logic            busy_q;
  logic            fix_q;
  logic            done_q;
  logic [CNTW-1:0] cnt_q;
  logic            neg_q;
  logic [DW-1:0]   mag_q;
  logic [NW-1:0]   rem_q;
  logic [DW-1:0]   quot_q;
  logic            rem_nz_q;

  logic [NW:0] shifted;
  logic [NW:0] diff;
  logic        ge;

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem_q, mag_q[DW-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign ge      = shifted >= {1'b0, divisor_i};

  // Control: busy for DW steps, then a sign-fix step (fix_q), then done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          fix_q  <= 1'b1;
        end
      end
    end
  end

  // Datapath: magnitude on start, quotient bits shift into the magnitude register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      mag_q <= dividend_i[DW-1] ? (~dividend_i) + DW'(1) : dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[NW-1:0] : shifted[NW-1:0];
      mag_q <= {mag_q[DW-2:0], ge};
    end
    // Floor quotient: -Q-1 with a remainder, -Q without, for a negative dividend.
    if (fix_q) begin
      quot_q   <= neg_q ? (~mag_q) + DW'(rem_q == '0) : mag_q;
      rem_nz_q <= rem_q != '0;
    end
  end

  assign done_o   = done_q;
  assign quot_o   = quot_q;
  assign rem_nz_o = rem_nz_q;

  // A new division never starts while one is in progress.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (!busy_q && !fix_q))
    else $error("divider started while busy");

endmodule

/* hdl/krst_dp.sv */
// Datapath of the keyed running statistics table: key and statistics stores,
// search index, fill level, mean update and result registers.
// Depends on krst_pkg, krst_ram and krst_div.
module krst_dp #(
  parameter int unsigned TABLE_DEPTH    = krst_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MEAN_FRAC_BITS = krst_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  krst_pkg::dp_cmd_t                     cmd_i,
  output krst_pkg::dp_stat_t                    stat_o,
  input  logic                                  cfg_valid_i,
  input  logic [krst_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic [krst_pkg::KEY_W-1:0]            key_id_i,
  input  logic signed [krst_pkg::SAMPLE_W-1:0]  sample_value_i,
  output logic [1:0]                            status_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]  recent_sample_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]  min_value_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]  max_value_o,
  output logic signed [krst_pkg::MEAN_OUT_W-1:0] mean_fixed_o,
  output logic [krst_pkg::COUNT_W-1:0]          sample_count_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SMW = krst_pkg::SAMPLE_W;
  localparam int unsigned NW = krst_pkg::COUNT_W;
  localparam int unsigned MW = SMW + MEAN_FRAC_BITS;
  localparam int unsigned DW = MW + 1;
  localparam int unsigned SW = 3 * SMW + MW + NW;
  localparam int unsigned OFF_COUNT = 0;
  localparam int unsigned OFF_MEAN = NW;
  localparam int unsigned OFF_MAX = NW + MW;
  localparam int unsigned OFF_MIN = NW + MW + SMW;
  localparam int unsigned OFF_LAST = NW + MW + 2 * SMW;

  // Control registers.
  logic [krst_pkg::CFG_W-1:0] keys_q;
  logic [CW-1:0]              fill_q;
  logic [CW-1:0]              idx_q;

  // Item and working registers.
  logic [krst_pkg::KEY_W-1:0] key_q;
  logic signed [SMW-1:0]      sample_q;
  logic signed [SMW-1:0]      min_q;
  logic signed [SMW-1:0]      max_q;
  logic [NW-1:0]              cnt_q;
  logic signed [MW-1:0]       mean_q;
  logic signed [DW-1:0]       d_q;
  logic signed [MW-1:0]       sum_q;

  // Result registers.
  krst_pkg::status_e status_q;
  logic [SW-1:0]     out_q;

  // Store ports.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [krst_pkg::KEY_W-1:0] key_rdata;
  logic [SW-1:0]              stat_rdata;
  logic [SW-1:0]              stat_wdata;

  logic signed [SMW-1:0] rd_min;
  logic signed [SMW-1:0] rd_max;
  logic signed [MW-1:0]  rd_mean;
  logic [NW-1:0]         rd_count;
  logic signed [MW-1:0]  sample_fix;
  logic signed [MW-1:0]  mean_new;
  logic                  table_full;
  logic                  emit;

  logic                 div_done;
  logic signed [DW-1:0] div_quot;
  logic                 div_rem_nz;

  // Fields of the statistics word read from the store.
  assign rd_min     = stat_rdata[OFF_MIN +: SMW];
  assign rd_max     = stat_rdata[OFF_MAX +: SMW];
  assign rd_mean    = stat_rdata[OFF_MEAN +: MW];
  assign rd_count   = stat_rdata[OFF_COUNT +: NW];
  assign sample_fix = MW'(sample_q) <<< MEAN_FRAC_BITS;

  // Final mean: truncate toward zero where the floor sum went negative.
  assign mean_new = sum_q + MW'(sum_q < 0 && div_rem_nz);

  // The limit in force is the smaller of the register and the table depth.
  assign table_full = (32'(fill_q) >= 32'(keys_q)) || (32'(fill_q) >= TABLE_DEPTH);

  assign stat_o.search_end = idx_q >= fill_q;
  assign stat_o.key_hit    = key_rdata == key_q;
  assign stat_o.table_full = table_full;
  assign stat_o.div_done   = div_done;

  // Store write: a new entry at the fill level, or an update at the hit index.
  assign ram_we    = cmd_i.append || cmd_i.write_back;
  assign ram_waddr = cmd_i.append ? fill_q[AW-1:0] : idx_q[AW-1:0];
  assign stat_wdata = cmd_i.append
    ? {sample_q, sample_q, sample_q, sample_fix, NW'(1)}
    : {sample_q, min_q, max_q, mean_new, cnt_q};
  assign emit = cmd_i.append || cmd_i.write_back || cmd_i.drop || cmd_i.clear;

  krst_ram #(
    .WIDTH (krst_pkg::KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (key_q),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (key_rdata)
  );

  krst_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (stat_wdata),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (stat_rdata)
  );

  krst_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (d_q),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  // Configuration register, fill level and search index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= krst_pkg::KEYS_IN_USE_RESET;
      fill_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        keys_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        fill_q <= '0;
      end else if (cmd_i.append) begin
        fill_q <= fill_q + CW'(1);
      end
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
    end
  end

  // Working registers for the item and the hit entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q    <= key_id_i;
      sample_q <= sample_value_i;
    end
    if (cmd_i.hit_load) begin
      cnt_q  <= (rd_count == '1) ? rd_count : rd_count + NW'(1);
      min_q  <= (sample_q < rd_min) ? sample_q : rd_min;
      max_q  <= (sample_q > rd_max) ? sample_q : rd_max;
      mean_q <= rd_mean;
      d_q    <= DW'(sample_fix) - DW'(rd_mean);
    end
    if (cmd_i.mean_sum) begin
      sum_q <= MW'(DW'(mean_q) + div_quot);
    end
  end

  // Result registers, loaded once per item.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (cmd_i.clear) begin
        status_q <= krst_pkg::STATUS_CLEARED;
      end else if (cmd_i.drop) begin
        status_q <= krst_pkg::STATUS_FULL;
      end else if (cmd_i.append) begin
        status_q <= krst_pkg::STATUS_NEW;
      end else begin
        status_q <= krst_pkg::STATUS_UPDATED;
      end
      out_q <= (cmd_i.clear || cmd_i.drop) ? '0 : stat_wdata;
    end
  end

  assign status_o        = status_q;
  assign recent_sample_o = out_q[OFF_LAST +: SMW];
  assign min_value_o     = out_q[OFF_MIN +: SMW];
  assign max_value_o     = out_q[OFF_MAX +: SMW];
  assign mean_fixed_o    = krst_pkg::MEAN_OUT_W'(signed'(out_q[OFF_MEAN +: MW]));
  assign sample_count_o  = out_q[OFF_COUNT +: NW];

  // The fill level never passes the table depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= TABLE_DEPTH)
    else $error("fill level beyond table depth");

  // A new entry is appended only below the limit, and grows the fill by one.
  a_append_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> !table_full)
    else $error("append into a full table");

  a_append_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |=> fill_q == $past(fill_q) + CW'(1))
    else $error("fill level did not advance on append");

endmodule

/* hdl/krst_ctrl.sv */
// Controller of the keyed running statistics table: sequences the key search,
// the mean division, the store write and the result handshake.
// Depends on krst_pkg.
module krst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               action_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output krst_pkg::dp_cmd_t  cmd_o,
  input  krst_pkg::dp_stat_t stat_i
);

  krst_pkg::state_e state_q;
  krst_pkg::state_e state_d;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             out_free;
  logic             emit;

  // The result register can take a word when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      krst_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = action_i ? krst_pkg::ST_CLR : krst_pkg::ST_RD;
        end
      end
      krst_pkg::ST_RD: begin
        state_d = stat_i.search_end ? krst_pkg::ST_MISS : krst_pkg::ST_CMP;
      end
      krst_pkg::ST_CMP: begin
        state_d = stat_i.key_hit ? krst_pkg::ST_DSTART : krst_pkg::ST_RD;
      end
      krst_pkg::ST_DSTART: state_d = krst_pkg::ST_DIV;
      krst_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = krst_pkg::ST_SUM;
        end
      end
      krst_pkg::ST_SUM: state_d = krst_pkg::ST_WB;
      krst_pkg::ST_WB, krst_pkg::ST_MISS, krst_pkg::ST_CLR: begin
        if (out_free) begin
          state_d = krst_pkg::ST_IDLE;
        end
      end
      default: state_d = krst_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      krst_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      krst_pkg::ST_RD: ;
      krst_pkg::ST_CMP: begin
        cmd_o.hit_load = stat_i.key_hit;
        cmd_o.idx_inc  = !stat_i.key_hit;
      end
      krst_pkg::ST_DSTART: cmd_o.div_start = 1'b1;
      krst_pkg::ST_DIV: ;
      krst_pkg::ST_SUM: cmd_o.mean_sum = 1'b1;
      krst_pkg::ST_WB: begin
        emit             = out_free;
        cmd_o.write_back = out_free;
      end
      krst_pkg::ST_MISS: begin
        emit         = out_free;
        cmd_o.append = out_free && !stat_i.table_full;
        cmd_o.drop   = out_free && stat_i.table_full;
      end
      krst_pkg::ST_CLR: begin
        emit        = out_free;
        cmd_o.clear = out_free;
      end
      default: ;
    endcase
  end

  // Result word valid flag.
  always_comb begin
    priority if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= krst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // One word in flight: no second accept right after an accept.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted while one is in work");

  // A clear word goes straight to the clear state.
  a_clear_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i) |=> state_q == krst_pkg::ST_CLR)
    else $error("clear word not routed to clear");

  // A result is never written over one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.write_back || cmd_o.append || cmd_o.drop || cmd_o.clear)
      |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule

/* hdl/keyed_running_stats_table_unit.sv */
// Top level of the keyed running statistics table.
// Joins the controller (krst_ctrl) and the datapath (krst_dp); depends on krst_pkg.
//
//   Channel  Dir  Handshake                  Word
//   in       in   in_valid_i / in_ready_o    action_i, key_id_i, sample_value_i
//   out      out  out_valid_o / out_ready_i  status_o, recent_sample_o, min_value_o,
//                                            max_value_o, mean_fixed_o, sample_count_o
//   cfg      in   cfg_valid_i / cfg_ready_o  cfg_data_i (keys in use)
//
// One word at a time. An update searches the filled entries, each with one store
// read (ST_RD) and one key compare (ST_CMP). On a miss it appends or drops the word;
// on a hit the serial mean divider runs (ST_DSTART, ST_DIV, ST_SUM) before ST_WB.
// A finished result waits in the output register while the next word is taken.
// Reset is asynchronous and active low; it empties the table without a sweep.
// A stalled output holds the block only when a second result is ready to go.
module keyed_running_stats_table_unit #(
  parameter int unsigned TABLE_DEPTH    = krst_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MEAN_FRAC_BITS = krst_pkg::MEAN_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   action_i,
  input  logic [krst_pkg::KEY_W-1:0]             key_id_i,
  input  logic signed [krst_pkg::SAMPLE_W-1:0]   sample_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [1:0]                             status_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]   recent_sample_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]   min_value_o,
  output logic signed [krst_pkg::SAMPLE_W-1:0]   max_value_o,
  output logic signed [krst_pkg::MEAN_OUT_W-1:0] mean_fixed_o,
  output logic [krst_pkg::COUNT_W-1:0]           sample_count_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [krst_pkg::CFG_W-1:0]             cfg_data_i
);

  krst_pkg::dp_cmd_t  cmd;
  krst_pkg::dp_stat_t stat;

  // The configuration register takes a word in any cycle.
  assign cfg_ready_o = 1'b1;

  krst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  krst_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .key_id_i        (key_id_i),
    .sample_value_i  (sample_value_i),
    .status_o        (status_o),
    .recent_sample_o (recent_sample_o),
    .min_value_o     (min_value_o),
    .max_value_o     (max_value_o),
    .mean_fixed_o    (mean_fixed_o),
    .sample_count_o  (sample_count_o)
  );

endmodule

/* dv/keyed_running_stats_table_unit_tb.sv */
// Self-checking testbench for the keyed running statistics table unit.
// It depends on krst_pkg for the field widths, the parameter defaults and the status codes.
// A scoreboard class keeps its own copy of the table and predicts every result word.
module keyed_running_stats_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes of an input word.
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam int unsigned DEPTH     = krst_pkg::TABLE_DEPTH_DEF;
  localparam int unsigned FRAC_BITS = krst_pkg::MEAN_FRAC_BITS_DEF;

  // One result word as the block returns it.
  typedef struct packed {
    krst_pkg::status_e                      status;
    logic signed [krst_pkg::SAMPLE_W-1:0]   last_v;
    logic signed [krst_pkg::SAMPLE_W-1:0]   min_v;
    logic signed [krst_pkg::SAMPLE_W-1:0]   max_v;
    logic signed [krst_pkg::MEAN_OUT_W-1:0] mean_v;
    logic [krst_pkg::COUNT_W-1:0]           count_v;
  } stats_word_t;

  // Scoreboard: mirrors the table, predicts each result word and checks what arrives.
  class stats_table_scoreboard;
    stats_word_t                          expected_stats_q[$];
    logic [krst_pkg::CFG_W-1:0]           keys_in_use;
    int unsigned                          fill_level;
    logic [krst_pkg::KEY_W-1:0]           key_tab[DEPTH];
    logic signed [krst_pkg::SAMPLE_W-1:0] last_tab[DEPTH];
    logic signed [krst_pkg::SAMPLE_W-1:0] min_tab[DEPTH];
    logic signed [krst_pkg::SAMPLE_W-1:0] max_tab[DEPTH];
    longint                               mean_tab[DEPTH];
    logic [krst_pkg::COUNT_W-1:0]         count_tab[DEPTH];
    int                                   errors;
    int                                   status_seen[4];

    function new();
      keys_in_use = krst_pkg::KEYS_IN_USE_RESET;
      fill_level  = 0;
      errors      = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_keys_in_use(logic [krst_pkg::CFG_W-1:0] value);
      keys_in_use = value;
    endfunction

    function int pending();
      return expected_stats_q.size();
    endfunction

    // New mean (mean*(n-1) + v) / n, truncated toward zero, done without overflow.
    function longint mean_step(longint mean, longint v, longint n);
      longint d;
      longint q;
      longint r;
      d = v - mean;
      q = d / n;
      r = d % n;
      if (r < 0) begin
        q -= 1;
        r += n;
      end
      q += mean;
      if (q < 0 && r != 0) q += 1;
      return q;
    endfunction

    function stats_word_t entry_word(krst_pkg::status_e st, int idx);
      stats_word_t w;
      w.status  = st;
      w.last_v  = last_tab[idx];
      w.min_v   = min_tab[idx];
      w.max_v   = max_tab[idx];
      w.mean_v  = mean_tab[idx][krst_pkg::MEAN_OUT_W-1:0];
      w.count_v = count_tab[idx];
      return w;
    endfunction

    // Applies one accepted input word to the mirrored table and queues the expected result.
    function void note_word(logic act, logic [krst_pkg::KEY_W-1:0] key,
                            logic signed [krst_pkg::SAMPLE_W-1:0] smp);
      stats_word_t                  w;
      int unsigned                  lim;
      longint                       sfix;
      int                           hit;
      logic [krst_pkg::COUNT_W-1:0] n;
      w = '0;
      if (act == ACT_CLEAR) begin
        fill_level = 0;
        w.status = krst_pkg::STATUS_CLEARED;
        expected_stats_q.push_back(w);
        return;
      end
      sfix = longint'(smp) <<< FRAC_BITS;
      lim  = (keys_in_use > DEPTH) ? DEPTH : keys_in_use;
      hit  = -1;
      for (int i = 0; i < fill_level; i++) begin
        if (hit < 0 && key_tab[i] == key) hit = i;
      end
      if (hit >= 0) begin
        // Known key: the count saturates, min and max follow the sample.
        n = count_tab[hit];
        if (n != '1) n = n + 1'b1;
        count_tab[hit] = n;
        last_tab[hit]  = smp;
        if (smp < min_tab[hit]) min_tab[hit] = smp;
        if (smp > max_tab[hit]) max_tab[hit] = smp;
        mean_tab[hit] = mean_step(mean_tab[hit], sfix, longint'(n));
        w = entry_word(krst_pkg::STATUS_UPDATED, hit);
      end else if (fill_level >= lim) begin
        // Unknown key with no room left: dropped, all statistics zero.
        w.status = krst_pkg::STATUS_FULL;
      end else begin
        key_tab[fill_level]   = key;
        last_tab[fill_level]  = smp;
        min_tab[fill_level]   = smp;
        max_tab[fill_level]   = smp;
        mean_tab[fill_level]  = sfix;
        count_tab[fill_level] = krst_pkg::COUNT_W'(1);
        w = entry_word(krst_pkg::STATUS_NEW, fill_level);
        fill_level++;
      end
      expected_stats_q.push_back(w);
    endfunction

    function bit field_differs(string name, logic [63:0] exp_v, logic [63:0] got_v);
      if (exp_v === got_v) return 1'b0;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      return 1'b1;
    endfunction

    // Compares one accepted result word with the oldest expectation.
    function void check_result_word(stats_word_t got);
      stats_word_t exp_w;
      bit          bad;
      if (expected_stats_q.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none, actual status %h",
                 $time, got.status);
        errors++;
        return;
      end
      exp_w = expected_stats_q.pop_front();
      status_seen[exp_w.status]++;
      bad = 1'b0;
      bad |= field_differs("status", 64'(exp_w.status), 64'(got.status));
      bad |= field_differs("recent_sample", 64'(exp_w.last_v), 64'(got.last_v));
      bad |= field_differs("min_value", 64'(exp_w.min_v), 64'(got.min_v));
      bad |= field_differs("max_value", 64'(exp_w.max_v), 64'(got.max_v));
      bad |= field_differs("mean_fixed", 64'(exp_w.mean_v), 64'(got.mean_v));
      bad |= field_differs("sample_count", 64'(exp_w.count_v), 64'(got.count_v));
      if (bad) errors++;
    endfunction

    function void report_leftover();
      if (expected_stats_q.size() != 0) begin
        $display("%0t: %0d expected result words never arrived", $time,
                 expected_stats_q.size());
        errors++;
      end
    endfunction
  endclass

  logic                                   clk_i = 1'b0;
  logic                                   rst_ni;
  logic                                   in_valid_i;
  logic                                   in_ready_o;
  logic                                   action_i;
  logic [krst_pkg::KEY_W-1:0]             key_id_i;
  logic signed [krst_pkg::SAMPLE_W-1:0]   sample_value_i;
  logic                                   out_valid_o;
  logic                                   out_ready_i;
  logic [1:0]                             status_o;
  logic signed [krst_pkg::SAMPLE_W-1:0]   recent_sample_o;
  logic signed [krst_pkg::SAMPLE_W-1:0]   min_value_o;
  logic signed [krst_pkg::SAMPLE_W-1:0]   max_value_o;
  logic signed [krst_pkg::MEAN_OUT_W-1:0] mean_fixed_o;
  logic [krst_pkg::COUNT_W-1:0]           sample_count_o;
  logic                                   cfg_valid_i;
  logic                                   cfg_ready_o;
  logic [krst_pkg::CFG_W-1:0]             cfg_data_i;

  stats_table_scoreboard board = new();

  int send_idle_pct = 19;
  int recv_idle_pct = 81;
  int cfg_writes    = 0;

  keyed_running_stats_table_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .key_id_i        (key_id_i),
    .sample_value_i  (sample_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .recent_sample_o (recent_sample_o),
    .min_value_o     (min_value_o),
    .max_value_o     (max_value_o),
    .mean_fixed_o    (mean_fixed_o),
    .sample_count_o  (sample_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // Free-running clock, 8 ns period.
  always #4 clk_i = ~clk_i;

  // Result side: check every accepted word, then choose the next ready at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        board.check_result_word('{krst_pkg::status_e'(status_o), recent_sample_o,
                                  min_value_o, max_value_o, mean_fixed_o,
                                  sample_count_o});
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offers one input word after an optional random gap and waits for it to be taken.
  task automatic send_word(input logic act, input logic [krst_pkg::KEY_W-1:0] key,
                           input logic signed [krst_pkg::SAMPLE_W-1:0] smp);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    key_id_i       <= key;
    sample_value_i <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_word(act, key, smp);
  endtask

  // Holds the input side until every expected result word has come back.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the key limit register; only called while the block is idle.
  task automatic write_keys_in_use(input logic [krst_pkg::CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_keys_in_use(value);
    cfg_writes++;
    @(posedge clk_i);
  endtask

  function automatic logic signed [krst_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          default: return 32'shFFFF_FFFF;
        endcase
      end
      1, 2: return $signed(32'($urandom_range(0, 200))) - 32'sd100;
      default: return $signed($urandom());
    endcase
  endfunction

  // Stimulus: directed words first, then random bursts over three idling patterns.
  initial begin
    logic [krst_pkg::KEY_W-1:0] key_pool[96];
    logic [krst_pkg::KEY_W-1:0] key_a;
    logic [krst_pkg::KEY_W-1:0] key_b;
    logic [krst_pkg::CFG_W-1:0] limit_pick;
    int                         pool_size;

    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    action_i       <= ACT_UPDATE;
    key_id_i       <= '0;
    sample_value_i <= '0;
    out_ready_i    <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_data_i     <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes of key and sample, mean rounding on both signs, clears.
    key_a = {$urandom(), $urandom()};
    key_b = {$urandom(), $urandom()};
    send_word(ACT_CLEAR, {$urandom(), $urandom()}, $signed($urandom()));
    send_word(ACT_UPDATE, '1, 32'sh7FFF_FFFF);
    send_word(ACT_UPDATE, '1, 32'sh8000_0000);
    send_word(ACT_UPDATE, '1, 32'sh0000_0000);
    send_word(ACT_UPDATE, '1, -32'sd1);
    send_word(ACT_UPDATE, '0, -32'sd1);
    send_word(ACT_UPDATE, '0, 32'sd3);
    send_word(ACT_UPDATE, '0, -32'sd7);
    send_word(ACT_CLEAR, '1, 32'shFFFF_FFFF);
    send_word(ACT_UPDATE, '0, 32'sd11);

    // Directed: a table limited to two keys overflows.
    wait_results_drained();
    write_keys_in_use(7'd2);
    send_word(ACT_UPDATE, key_a, 32'sd5);
    send_word(ACT_UPDATE, key_b, 32'sd6);
    send_word(ACT_UPDATE, '0, -32'sd20);

    // Directed: limit lowered below the fill level, known keys still found.
    wait_results_drained();
    write_keys_in_use(7'd1);
    send_word(ACT_UPDATE, key_a, -32'sd9);
    send_word(ACT_UPDATE, key_b, 32'sd1);

    // Directed: a zero limit drops every new key.
    wait_results_drained();
    write_keys_in_use(7'd0);
    send_word(ACT_CLEAR, '0, '0);
    send_word(ACT_UPDATE, key_a, 32'sd2);
    send_word(ACT_UPDATE, key_b, 32'sd3);

    // Directed: a limit above the depth acts as the full depth.
    wait_results_drained();
    write_keys_in_use(7'd127);
    send_word(ACT_UPDATE, key_a, 32'sd100);
    send_word(ACT_UPDATE, key_b, -32'sd100);
    send_word(ACT_UPDATE, key_a, 32'sd7);
    send_word(ACT_UPDATE, key_b, -32'sd8);

    // Random bursts: each draws keys from a fresh pool so that hits, appends
    // and overflows all occur; clears are rare so the table grows deep.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 19 : (mode == 1) ? 81 : 0;
      recv_idle_pct = (mode == 0) ? 81 : (mode == 1) ? 19 : 0;
      for (int burst = 0; burst < 4; burst++) begin
        wait_results_drained();
        case ($urandom_range(0, 6))
          0: limit_pick = 7'd0;
          1: limit_pick = 7'd1;
          2: limit_pick = 7'd2;
          3: limit_pick = 7'd64;
          4: limit_pick = 7'd127;
          5: limit_pick = 7'($urandom_range(3, 63));
          default: limit_pick = 7'($urandom_range(65, 126));
        endcase
        write_keys_in_use(limit_pick);
        pool_size = $urandom_range(2, 90);
        for (int k = 0; k < pool_size; k++) key_pool[k] = {$urandom(), $urandom()};
        for (int item = 0; item < 42; item++) begin
          if ($urandom_range(0, 99) < 3)
            send_word(ACT_CLEAR, {$urandom(), $urandom()}, $signed($urandom()));
          else
            send_word(ACT_UPDATE, key_pool[$urandom_range(0, pool_size - 1)],
                      random_sample());
        end
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk_i);
    board.report_leftover();
    $display("Checked %0d result words: %0d new keys, %0d updates, %0d drops, %0d clears.",
             board.status_seen[krst_pkg::STATUS_NEW] +
             board.status_seen[krst_pkg::STATUS_UPDATED] +
             board.status_seen[krst_pkg::STATUS_FULL] +
             board.status_seen[krst_pkg::STATUS_CLEARED],
             board.status_seen[krst_pkg::STATUS_NEW],
             board.status_seen[krst_pkg::STATUS_UPDATED],
             board.status_seen[krst_pkg::STATUS_FULL],
             board.status_seen[krst_pkg::STATUS_CLEARED]);
    $display("Key limit written %0d times, zero, one, two, full depth and above it among them.",
             cfg_writes);
    if (board.errors == 0) begin
      $display("keyed_running_stats_table_unit_tb passed");
    end else begin
      $display("keyed_running_stats_table_unit_tb failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $display("Timeout at %0t with %0d result words outstanding.", $time, board.pending());
    $display("keyed_running_stats_table_unit_tb failed");
    $finish;
  end

endmodule
